// ===== sv/iols_pkg.sv =====
// Shared types and codes for the indexed ordered list store.
// Used by iols_cell and indexed_ordered_list_store; no dependencies.
`default_nettype none

package iols_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FIELD_WIDTH     = 32;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_INSERT     = 3'd4,
    FUNC_ERASE      = 3'd5,
    FUNC_CLEAR      = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ERR  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // Per-cell move selection for a row update.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LOWER = 2'd1,
    CELL_FROM_UPPER = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_e;

endpackage

`default_nettype wire

// ===== sv/iols_cell.sv =====
// One storage cell of the list row: holds a value, or takes it from a
// neighbor or from the new item. Depends on iols_pkg.
`default_nettype none

module iols_cell import iols_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire cell_op_e               op_i,
  input  wire logic [VALUE_WIDTH-1:0] lower_i,
  input  wire logic [VALUE_WIDTH-1:0] upper_i,
  input  wire logic [VALUE_WIDTH-1:0] load_i,
  output      logic [VALUE_WIDTH-1:0] value_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:       value_d = value_q;
      CELL_FROM_LOWER: value_d = lower_i;
      CELL_FROM_UPPER: value_d = upper_i;
      CELL_LOAD:       value_d = load_i;
      default:         value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== sv/indexed_ordered_list_store.sv =====
// Top level of the indexed ordered list store: control and a row of iols_cell.
// Depends on iols_pkg and iols_cell.
//
// Usage:
//   Raise start_i with func_i, position_i and value_i; the item is taken at
//   the clock edge where start_i is high and busy_o is low. Cell 0 is the
//   front of the list. Inserts open a gap by moving every cell at or above
//   the position one place up at the accepting edge; pops and erases close the
//   gap by moving cells down the same way.
//   Order: the row and count update at the accepting edge; while busy_o is
//   high, front and back are captured from the updated row, and done_o
//   rises at that same edge, then shows status_o, removed_value_o, count_o,
//   front_value_o and back_value_o. busy_o is high for the one cycle between.
//   Back-to-back: busy_o holds off the next item, since the row update is
//   followed by the read of the back cell through the count-indexed mux.
//   The receiver cannot stall: each result is on the ports for one cycle.
//   Reset empties the list (count zero) and drops any item in flight; cell
//   contents are not cleared and are never read before being written.
`default_nettype none

module indexed_ordered_list_store import iols_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W      = $clog2(CAPACITY)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [2:0]                    func_i,
  input  wire logic [CNT_W-1:0]              position_i,
  input  wire logic signed [FIELD_WIDTH-1:0] value_i,
  output      logic                          busy_o,
  output      logic                          done_o,
  output      logic [1:0]                    status_o,
  output      logic signed [FIELD_WIDTH-1:0] removed_value_o,
  output      logic [CNT_W-1:0]              count_o,
  output      logic signed [FIELD_WIDTH-1:0] front_value_o,
  output      logic signed [FIELD_WIDTH-1:0] back_value_o
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  function automatic logic [VALUE_WIDTH-1:0] to_cell(logic signed [FIELD_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] to_field(logic [VALUE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_WIDTH-1:0];
  endfunction

  logic                   accept;
  logic                   pend_q;
  logic                   done_q;
  logic [CNT_W-1:0]       count_q, count_d;
  status_e                status_q, status_d;
  logic [FIELD_WIDTH-1:0] removed_q, removed_d;
  logic [FIELD_WIDTH-1:0] front_q, back_q;

  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  cell_op_e               cell_op  [CAPACITY];
  logic [VALUE_WIDTH-1:0] load_val;
  logic [VALUE_WIDTH-1:0] back_rd;
  logic [CNT_W-1:0]       last;

  logic                   full;
  logic                   empty;
  logic                   do_ins, do_del;
  logic [CNT_W-1:0]       at;

  assign accept   = start_i && !pend_q;
  assign full     = (count_q == CAP_C);
  assign empty    = (count_q == '0);
  assign last     = count_q - CNT_W'(1);
  assign back_rd  = cell_val[last[IDX_W-1:0]];
  assign load_val = to_cell(value_i);

  // Decode the request against the current count.
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    at        = '0;
    status_d  = STATUS_OK;
    removed_d = '0;
    count_d   = count_q;
    unique case (func_e'(func_i))
      FUNC_PUSH_FRONT: begin
        if (full) status_d = STATUS_FULL;
        else do_ins = 1'b1;
      end
      FUNC_PUSH_BACK: begin
        if (full) status_d = STATUS_FULL;
        else begin
          do_ins = 1'b1;
          at     = count_q;
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) status_d = STATUS_ERR;
        else begin
          do_del    = 1'b1;
          removed_d = to_field(cell_val[0]);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) status_d = STATUS_ERR;
        else begin
          do_del    = 1'b1;
          at        = last;
          removed_d = to_field(back_rd);
        end
      end
      FUNC_INSERT: begin
        if (full) status_d = STATUS_FULL;
        else begin
          do_ins = 1'b1;
          at     = (position_i < count_q) ? position_i : count_q;
        end
      end
      FUNC_ERASE: begin
        if (position_i >= count_q) status_d = STATUS_ERR;
        else begin
          do_del = 1'b1;
          at     = position_i;
        end
      end
      FUNC_CLEAR: count_d = '0;
      default:    status_d = STATUS_ERR;
    endcase
    if (do_ins) count_d = count_q + CNT_W'(1);
    if (do_del) count_d = last;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_val[i+1];
    end

    // Open the gap above the insert point, or close it above the erase point.
    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (accept && do_ins) begin
        if (CNT_W'(i) == at) cell_op[i] = CELL_LOAD;
        else if (CNT_W'(i) > at && CNT_W'(i) <= count_q) cell_op[i] = CELL_FROM_LOWER;
      end else if (accept && do_del) begin
        if (CNT_W'(i) >= at && CNT_W'(i + 1) < count_q) cell_op[i] = CELL_FROM_UPPER;
      end
    end

    iols_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[i]),
      .lower_i(lower),
      .upper_i(upper),
      .load_i (load_val),
      .value_o(cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= pend_q;
      if (accept) begin
        pend_q  <= 1'b1;
        count_q <= count_d;
      end else begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
    // Capture ends from the updated row.
    if (pend_q) begin
      front_q <= empty ? '0 : to_field(cell_val[0]);
      back_q  <= empty ? '0 : to_field(back_rd);
    end
  end

  assign busy_o          = pend_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;
  assign front_value_o   = front_q;
  assign back_value_o    = back_q;

  a_done_follows_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(pend_q))
    else $error("result strobe without an item in flight");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("busy not raised after accepting an item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("count exceeds capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STATUS_FULL) |-> (count_q == CAP_C))
    else $error("full status reported below capacity");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (func_i == FUNC_POP_FRONT || func_i == FUNC_POP_BACK) && !empty)
      |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not decrement count");

endmodule

`default_nettype wire
